// ----- sv/rrd_pkg.sv -----
// Shared types, constants and helpers for the Rice residual decoder.
// Used by the front queue, the bit-serial back end, the top level and the checker.
package rrd_pkg;

    localparam int BYTE_W      = 8;
    localparam int SAMPLE_W    = 32;
    localparam int K_W         = 5;
    localparam int CNT_W       = 16;
    localparam int BIT_IDX_W   = 3;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'hFFFF;

    localparam logic [CFG_ADDR_W-1:0] REG_RICE_PARAM   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
        logic              last_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       frame_done;
        logic                       error;
    } result_t;

    typedef struct packed {
        logic [K_W-1:0]   rice_param;
        logic [CNT_W-1:0] frame_limit;
    } cfg_t;

    localparam result_t ERR_RESULT = '{sample: '0, frame_done: 1'b0, error: 1'b1};

    // Even u maps to u/2, odd u to -(u+1)/2.
    function automatic logic signed [SAMPLE_W-1:0] zigzag(input logic [SAMPLE_W-1:0] u);
        logic [SAMPLE_W-1:0] s;
        s = (u >> 1) ^ {SAMPLE_W{u[0]}};
        return $signed(s);
    endfunction

endpackage

// ----- sv/rrd_front.sv -----
// Input side of the Rice residual decoder: accepts bytes and queues them.
// Depends on rrd_pkg for the item type and queue depth.
module rrd_front
    import rrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  in_item_t s_item,
    output logic     q_valid,
    output in_item_t q_item,
    input  logic     q_pop
);

    in_item_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= s_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- sv/rrd_back.sv -----
// Bit-serial Rice decoder: one bit of the queued byte per cycle unless stalled, zigzag map,
// frame bookkeeping and the output register. Depends on rrd_pkg.
module rrd_back
    import rrd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_valid,
    input  in_item_t q_item,
    output logic     q_pop,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_result,
    output logic     out_run_end
);

    typedef enum logic [0:0] {ST_BITS, ST_TAIL} state_t;

    state_t                 state_reg;
    logic [BIT_IDX_W-1:0]   bit_idx_reg;
    logic                   in_rem_reg;
    logic [SAMPLE_W-1:0]    quot_reg;
    logic [SAMPLE_W-1:0]    rem_reg;
    logic [K_W-1:0]         left_reg;
    logic [CNT_W-1:0]       done_reg;
    logic                   fin_reg;
    result_t                pend_reg;
    logic                   pend_v_reg;
    logic                   extra_err_reg;
    result_t                out_reg;
    logic                   out_last_reg;
    logic                   out_v_reg;

    logic                   first_bit;
    logic                   last_bit;
    logic                   clr;
    logic                   bit_v;
    logic                   in_rem_e;
    logic [SAMPLE_W-1:0]    quot_e;
    logic [SAMPLE_W-1:0]    rem_e;
    logic [K_W-1:0]         left_e;
    logic [CNT_W-1:0]       done_e;
    logic                   fin_e;
    logic                   complete_e;
    logic [SAMPLE_W-1:0]    rem_shift;
    logic [K_W-1:0]         left_dec;
    logic [CNT_W-1:0]       done_inc;
    logic [SAMPLE_W-1:0]    code_u;
    logic                   do_finish;
    logic                   frame_hit;
    logic                   in_rem_next;
    logic [SAMPLE_W-1:0]    quot_next;
    logic [SAMPLE_W-1:0]    rem_next;
    logic [K_W-1:0]         left_next;
    logic [CNT_W-1:0]       done_next;
    logic                   fin_next;
    logic                   new_v;
    result_t                new_res;
    logic                   err_v;
    logic [1:0]             n_items;
    logic                   can_push;
    logic                   push_need;
    result_t                push_item;
    logic                   push_last;
    result_t                second_item;
    logic                   advance;

    assign out_valid   = out_v_reg;
    assign out_result  = out_reg;
    assign out_run_end = out_last_reg;

    assign first_bit = (bit_idx_reg == '1);
    assign last_bit  = (bit_idx_reg == '0);
    assign clr       = first_bit && q_item.frame_start;
    assign bit_v     = q_item.data_byte[bit_idx_reg];

    // frame_start clears the decode state ahead of the first bit
    assign in_rem_e = clr ? 1'b0 : in_rem_reg;
    assign quot_e   = clr ? '0 : quot_reg;
    assign rem_e    = clr ? '0 : rem_reg;
    assign left_e   = clr ? '0 : left_reg;
    assign done_e   = clr ? '0 : done_reg;
    assign fin_e    = clr ? 1'b0 : fin_reg;

    assign complete_e = fin_e || (done_e >= cfg.frame_limit);
    assign rem_shift  = {rem_e[SAMPLE_W-2:0], bit_v};
    assign left_dec   = left_e - 1'b1;
    assign done_inc   = done_e + 1'b1;
    assign code_u     = (quot_e << cfg.rice_param) | (in_rem_e ? rem_shift : rem_e);
    assign frame_hit  = (done_inc >= cfg.frame_limit);

    always_comb
    begin
        in_rem_next = in_rem_e;
        quot_next   = quot_e;
        rem_next    = rem_e;
        left_next   = left_e;
        done_next   = done_e;
        fin_next    = fin_e;
        do_finish   = 1'b0;
        if (!complete_e)
        begin
            if (!in_rem_e)
            begin
                if (bit_v)
                begin
                    quot_next = quot_e + 1'b1;
                end
                else if (cfg.rice_param == '0)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    in_rem_next = 1'b1;
                    rem_next    = '0;
                    left_next   = cfg.rice_param;
                end
            end
            else
            begin
                rem_next  = rem_shift;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    do_finish = 1'b1;
                end
            end
        end
        if (do_finish)
        begin
            in_rem_next = 1'b0;
            quot_next   = '0;
            rem_next    = '0;
            left_next   = '0;
            done_next   = done_inc;
            fin_next    = fin_e || frame_hit;
        end
    end

    assign new_v   = do_finish;
    assign new_res = '{sample: zigzag(code_u), frame_done: frame_hit, error: 1'b0};
    assign err_v   = last_bit && q_item.last_byte
                     && !(fin_next || (done_next >= cfg.frame_limit));
    assign n_items = 2'(pend_v_reg) + 2'(new_v) + 2'(err_v);
    assign can_push = !out_v_reg || out_ready;

    // Results of one byte go out in order: held sample, new sample, error.
    always_comb
    begin
        second_item = pend_v_reg ? (new_v ? new_res : ERR_RESULT) : ERR_RESULT;
        push_item   = pend_reg;
        push_last   = 1'b0;
        push_need   = 1'b0;
        if (state_reg == ST_TAIL)
        begin
            push_need = 1'b1;
            push_last = !extra_err_reg;
        end
        else if (last_bit)
        begin
            push_need = (n_items != 2'd0);
            push_last = (n_items == 2'd1);
            push_item = pend_v_reg ? pend_reg : (new_v ? new_res : ERR_RESULT);
        end
        else
        begin
            push_need = pend_v_reg && new_v;
        end
    end

    assign advance = q_valid && (!push_need || can_push);
    assign q_pop   = (state_reg == ST_BITS) && advance && last_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BITS;
            bit_idx_reg   <= '1;
            in_rem_reg    <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            left_reg      <= '0;
            done_reg      <= '0;
            fin_reg       <= 1'b0;
            pend_reg      <= ERR_RESULT;
            pend_v_reg    <= 1'b0;
            extra_err_reg <= 1'b0;
            out_reg       <= ERR_RESULT;
            out_last_reg  <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_BITS:
                begin
                    if (advance)
                    begin
                        in_rem_reg  <= in_rem_next;
                        quot_reg    <= quot_next;
                        rem_reg     <= rem_next;
                        left_reg    <= left_next;
                        done_reg    <= done_next;
                        fin_reg     <= fin_next || err_v;
                        bit_idx_reg <= bit_idx_reg - 1'b1;
                        if (push_need)
                        begin
                            out_reg      <= push_item;
                            out_last_reg <= push_last;
                            out_v_reg    <= 1'b1;
                        end
                        if (last_bit)
                        begin
                            pend_reg      <= second_item;
                            pend_v_reg    <= (n_items >= 2'd2);
                            extra_err_reg <= (n_items == 2'd3);
                            if (n_items >= 2'd2)
                            begin
                                state_reg <= ST_TAIL;
                            end
                        end
                        else if (new_v)
                        begin
                            pend_reg   <= new_res;
                            pend_v_reg <= 1'b1;
                        end
                    end
                end
                ST_TAIL:
                begin
                    if (can_push)
                    begin
                        out_reg      <= pend_reg;
                        out_last_reg <= push_last;
                        out_v_reg    <= 1'b1;
                        if (extra_err_reg)
                        begin
                            pend_reg      <= ERR_RESULT;
                            extra_err_reg <= 1'b0;
                        end
                        else
                        begin
                            pend_v_reg <= 1'b0;
                            state_reg  <= ST_BITS;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_BITS;
                end
            endcase
        end
    end

endmodule

// ----- sv/rice_residual_decoder.sv -----
// Rice residual decoder top level: configuration registers, byte queue, decoder.
// Depends on rrd_pkg, rrd_front and rrd_back.
//
// Bytes arrive on the s_ stream and are read most significant bit first; each Rice
// code (unary quotient ended by a zero, then rice_param remainder bits) yields one
// zigzag-mapped signed sample on the m_ stream. The decoder core walks one bit per
// cycle unless stalled; when the last bit of a byte leaves two or three results to send
// (a held sample, a new sample, an early-end error) the rest go out from a tail state.
// A 4-entry input queue lets the sender run ahead of the decoder, and an output
// register lets decoding continue while a result waits to be taken. Up to
// nine results follow one byte; tlast marks the last of them. Write rice_param and
// sample_count only while the block is idle. A byte with the frame_start flag
// restarts the frame; after sample_count samples the rest of the bits are dropped.
module rice_residual_decoder
    import rrd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,    // [7:0] data_byte
    input  logic                  s_tuser,    // [0] frame_start
    input  logic                  s_tlast,    // last_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,    // [31:0] sample
    output logic [1:0]            m_tuser,    // [0] frame_done, [1] error
    output logic                  m_tlast,    // run_end
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [K_W-1:0]   rice_param_reg;
    logic [CNT_W-1:0] sample_count_reg;
    cfg_t             cfg;
    in_item_t         s_item;
    in_item_t         q_item;
    logic             q_valid;
    logic             q_pop;
    result_t          out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_param_reg   <= '0;
            sample_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_RICE_PARAM:   rice_param_reg   <= cfg_wdata[K_W-1:0];
                REG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[CNT_W-1:0];
                default:          rice_param_reg   <= rice_param_reg;
            endcase
        end
    end

    assign cfg.rice_param  = rice_param_reg;
    assign cfg.frame_limit = (sample_count_reg > MAX_SAMPLES) ? MAX_SAMPLES : sample_count_reg;

    assign s_item.data_byte   = s_tdata;
    assign s_item.frame_start = s_tuser;
    assign s_item.last_byte   = s_tlast;

    rrd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_item   (s_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rrd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result),
        .out_run_end (m_tlast)
    );

    assign m_tdata = out_result.sample;
    assign m_tuser = {out_result.error, out_result.frame_done};

endmodule

// ----- sv/rrd_checker.sv -----
// Port-level checks on the result stream of the Rice residual decoder.
// Depends on rrd_pkg; bound to rice_residual_decoder below.
module rrd_checker
    import rrd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [SAMPLE_W-1:0] m_tdata,
    input logic [1:0]          m_tuser,
    input logic                m_tlast
);

    // an error item carries a zero sample
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("error item with nonzero sample");

    // the error item is always the last one for its byte
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast)
        else $error("error item not marked as run end");

    // a completed frame never also reports an early end
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("frame_done and error set together");

    // hold a stalled item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output item changed");

endmodule

bind rice_residual_decoder rrd_checker u_rrd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
